// ===== rtl/gscc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid segment collision check: shared types and constants
// Operation codes, coordinate width and the walk sequencer states.
// ----------------------------------------------------------------------------
package gscc_pkg;

  localparam int CoordW = 8;
  localparam int SlopeW = 17;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [SlopeW-1:0] slope_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_NEIGH
  } state_e;

endpackage

// ===== rtl/gscc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gscc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/grid_segment_collision_check_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid segment collision check unit
// Holds a one-bit obstacle map and walks the grid line between two cells,
// testing each visited cell and its lower-left diagonal neighbour.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Payload
//  --------  -----------------  -----------------------------------------------
//  item in   start_i, busy_o    op_i, cell_x_i, cell_y_i, cell_blocked_i,
//                               start_x_i, start_y_i, goal_x_i, goal_y_i
//  result    done_o (strobe)    path_free_o
//
//  An item is taken when start_i is high and busy_o is low. A write item
//  updates the map and busy_o stays low. A check item walks the line from
//  the start cell to the goal cell; each step reads the visited cell and
//  then its neighbour through the single read port of the map RAM. The
//  result strobe lasts one cycle and cannot be stalled. Reset clears the
//  sequencer only; the map is undefined until written.
// ----------------------------------------------------------------------------
module grid_segment_collision_check_unit #(
  parameter int GRID_WIDTH  = 256,
  parameter int GRID_HEIGHT = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic       op_i,
  input  logic [7:0] cell_x_i,
  input  logic [7:0] cell_y_i,
  input  logic       cell_blocked_i,
  input  logic [7:0] start_x_i,
  input  logic [7:0] start_y_i,
  input  logic [7:0] goal_x_i,
  input  logic [7:0] goal_y_i,
  output logic       done_o,
  output logic       path_free_o
);

  localparam int MapCols = (GRID_WIDTH < 256) ? GRID_WIDTH : 256;
  localparam int MapRows = (GRID_HEIGHT < 256) ? GRID_HEIGHT : 256;
  localparam int ColBits = $clog2(MapCols);
  localparam int RowBits = $clog2(MapRows);
  localparam int AddrW   = ColBits + RowBits;
  localparam int MapDepth = 2 ** AddrW;

  function automatic logic [AddrW-1:0] map_addr(gscc_pkg::coord_t col,
                                                 gscc_pkg::coord_t row);
    return {row[RowBits-1:0], col[ColBits-1:0]};
  endfunction

  function automatic logic in_grid(gscc_pkg::coord_t col, gscc_pkg::coord_t row);
    return (32'(col) < GRID_WIDTH) && (32'(row) < GRID_HEIGHT);
  endfunction

  gscc_pkg::state_e state_q, state_d;

  gscc_pkg::coord_t cx_q, cx_d, cy_q, cy_d;
  gscc_pkg::coord_t gx_q, gx_d, gy_q, gy_d;
  logic             xpos_q, xpos_d, ypos_q, ypos_d;
  logic [8:0]       nx2_q, nx2_d, ny2_q, ny2_d;
  gscc_pkg::slope_t lhs_q, lhs_d, rhs_q, rhs_d;
  logic             cell_ok_q, cell_ok_d;
  logic             nb_pend_q, nb_pend_d;
  logic             nb_ok_q, nb_ok_d;
  logic             done_q, done_d;
  logic             free_q, free_d;

  logic             accept;
  logic             wr_en;
  logic [AddrW-1:0] raddr;
  logic             rdata;
  logic             at_goal;
  logic             nb_hit;
  logic             cell_hit;
  gscc_pkg::coord_t nxt_x, nxt_y;
  gscc_pkg::coord_t nb_x, nb_y;
  gscc_pkg::coord_t abs_dx, abs_dy;

  assign accept  = start_i && !busy_o;
  assign wr_en   = accept && (op_i == gscc_pkg::OP_WRITE) && in_grid(cell_x_i, cell_y_i);
  assign at_goal = (cx_q == gx_q) && (cy_q == gy_q);
  assign nb_hit  = nb_pend_q && nb_ok_q && rdata;
  assign cell_hit = cell_ok_q && rdata;
  assign abs_dx  = (goal_x_i > start_x_i) ? 8'(goal_x_i - start_x_i)
                                          : 8'(start_x_i - goal_x_i);
  assign abs_dy  = (goal_y_i > start_y_i) ? 8'(goal_y_i - start_y_i)
                                          : 8'(start_y_i - goal_y_i);
  assign nb_x    = 8'(cx_q - 8'd1);
  assign nb_y    = 8'(cy_q - 8'd1);

  gscc_ram #(
    .WIDTH(1),
    .DEPTH(MapDepth)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(map_addr(cell_x_i, cell_y_i)),
    .wdata_i(cell_blocked_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gscc_pkg::ST_IDLE: begin
        if (accept && (op_i == gscc_pkg::OP_CHECK)) begin
          state_d = gscc_pkg::ST_STEP;
        end
      end
      gscc_pkg::ST_STEP: begin
        if (nb_hit || at_goal) begin
          state_d = gscc_pkg::ST_IDLE;
        end else begin
          state_d = gscc_pkg::ST_NEIGH;
        end
      end
      gscc_pkg::ST_NEIGH: begin
        if (cell_hit) begin
          state_d = gscc_pkg::ST_IDLE;
        end else begin
          state_d = gscc_pkg::ST_STEP;
        end
      end
      default: state_d = gscc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cx_d      = cx_q;
    cy_d      = cy_q;
    gx_d      = gx_q;
    gy_d      = gy_q;
    xpos_d    = xpos_q;
    ypos_d    = ypos_q;
    nx2_d     = nx2_q;
    ny2_d     = ny2_q;
    lhs_d     = lhs_q;
    rhs_d     = rhs_q;
    cell_ok_d = cell_ok_q;
    nb_pend_d = nb_pend_q;
    nb_ok_d   = nb_ok_q;
    done_d    = 1'b0;
    free_d    = free_q;
    nxt_x     = cx_q;
    nxt_y     = cy_q;
    raddr     = map_addr(nxt_x, nxt_y);
    unique case (state_q)
      gscc_pkg::ST_IDLE: begin
        if (accept && (op_i == gscc_pkg::OP_CHECK)) begin
          cx_d      = start_x_i;
          cy_d      = start_y_i;
          gx_d      = goal_x_i;
          gy_d      = goal_y_i;
          xpos_d    = goal_x_i > start_x_i;
          ypos_d    = goal_y_i > start_y_i;
          nx2_d     = {abs_dx, 1'b0};
          ny2_d     = {abs_dy, 1'b0};
          lhs_d     = gscc_pkg::SlopeW'(abs_dy);
          rhs_d     = gscc_pkg::SlopeW'(abs_dx);
          nb_pend_d = 1'b0;
        end
      end
      gscc_pkg::ST_STEP: begin
        if (nb_hit) begin
          done_d = 1'b1;
          free_d = 1'b0;
        end else if (at_goal) begin
          done_d = 1'b1;
          free_d = 1'b1;
        end else begin
          if (lhs_q <= rhs_q) begin
            nxt_x = xpos_q ? 8'(cx_q + 8'd1) : 8'(cx_q - 8'd1);
            lhs_d = gscc_pkg::SlopeW'(lhs_q + gscc_pkg::SlopeW'(ny2_q));
          end
          if (lhs_q >= rhs_q) begin
            nxt_y = ypos_q ? 8'(cy_q + 8'd1) : 8'(cy_q - 8'd1);
            rhs_d = gscc_pkg::SlopeW'(rhs_q + gscc_pkg::SlopeW'(nx2_q));
          end
          raddr     = map_addr(nxt_x, nxt_y);
          cx_d      = nxt_x;
          cy_d      = nxt_y;
          cell_ok_d = in_grid(nxt_x, nxt_y);
        end
      end
      gscc_pkg::ST_NEIGH: begin
        if (cell_hit) begin
          done_d = 1'b1;
          free_d = 1'b0;
        end else begin
          raddr     = map_addr(nb_x, nb_y);
          nb_pend_d = 1'b1;
          nb_ok_d   = (cx_q != 8'd0) && (cy_q != 8'd0) && in_grid(nb_x, nb_y);
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gscc_pkg::ST_IDLE;
      done_q    <= 1'b0;
      nb_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      done_q    <= done_d;
      nb_pend_q <= nb_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    gx_q      <= gx_d;
    gy_q      <= gy_d;
    xpos_q    <= xpos_d;
    ypos_q    <= ypos_d;
    nx2_q     <= nx2_d;
    ny2_q     <= ny2_d;
    lhs_q     <= lhs_d;
    rhs_q     <= rhs_d;
    cell_ok_q <= cell_ok_d;
    nb_ok_q   <= nb_ok_d;
    free_q    <= free_d;
  end

  assign busy_o      = state_q != gscc_pkg::ST_IDLE;
  assign done_o      = done_q;
  assign path_free_o = free_q;

endmodule
